>>> rtl/core/rcm_pkg.sv
`timescale 1ns / 1ps
package rcm_pkg;

  localparam int MaxLimbs  = 32;
  localparam int LimbW     = $clog2(MaxLimbs);
  localparam int CountW    = 6;
  localparam int ValW      = 62;
  localparam int ConstW    = 64;
  localparam int ProdW     = 128;
  localparam int BitCntW   = 7;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SETC  = 2'd1,
    CMD_MUL   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic CFG_SCALE = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ROUND,
    ST_RDQ,
    ST_MODINIT,
    ST_MODRUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       latch_in;
    logic [1:0] mul_step;
    logic       mul_en;
    logic       mul_clear;
    logic       round;
    logic       rd_q;
    logic       mod_init;
    logic       mod_step;
    logic       emit;
    logic       limb_sel_cnt;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       fac_wr;
  } ctrl_t;

  typedef struct packed {
    logic       mod_done;
    logic       cnt_last;
    logic       out_busy;
    logic       is_mul;
  } stat_t;

endpackage

>>> rtl/core/rcm_datapath.sv
`timescale 1ns / 1ps
module rcm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rcm_pkg::ValW-1:0]      scale_i,
  input  logic [rcm_pkg::CountW-1:0]    count_i,
  input  logic                          mod_wr_i,
  input  logic [rcm_pkg::LimbW-1:0]     mod_addr_i,
  input  logic [rcm_pkg::ValW-1:0]      mod_data_i,
  input  logic [rcm_pkg::LimbW-1:0]     in_limb_i,
  input  logic                          in_limb_ok_i,
  input  logic [rcm_pkg::ConstW-1:0]    const_i,
  input  logic [rcm_pkg::ValW-1:0]      coeff_i,
  input  logic                          is_mul_i,
  input  rcm_pkg::ctrl_t                ctrl_i,
  output rcm_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcm_pkg::ValW-1:0]      out_val_o,
  output logic [rcm_pkg::LimbW-1:0]     out_limb_o,
  output logic                          out_last_o
);

  logic [rcm_pkg::ValW-1:0] mod_mem [rcm_pkg::MaxLimbs];
  logic [rcm_pkg::ValW-1:0] fac_mem [rcm_pkg::MaxLimbs];
  logic [rcm_pkg::MaxLimbs-1:0] fac_vld_q;

  logic [rcm_pkg::ValW-1:0]  a_q, q_q, fac_rd_q, r_q;
  logic [63:0]               ma_q, mb_q;
  logic                      neg_q, lneg_q, ok_q, mul_q;
  logic [rcm_pkg::ProdW-1:0] acc_q, val_q;
  logic [rcm_pkg::BitCntW-1:0] bit_q;
  logic [rcm_pkg::LimbW:0]   cnt_q;
  logic [rcm_pkg::LimbW-1:0] addr;
  logic [rcm_pkg::LimbW-1:0] limb_q;
  logic [31:0]               pa, pb;
  logic [63:0]               pp;
  logic [rcm_pkg::ProdW-1:0] rnd;
  logic [rcm_pkg::ValW:0]    r2;
  logic [rcm_pkg::ValW-1:0]  rfin;
  logic                      ov_q, ol_q;
  logic [rcm_pkg::ValW-1:0]  ovl_q;
  logic [rcm_pkg::LimbW-1:0] olm_q;

  assign addr = (ctrl_i.limb_sel_cnt && !mul_q) ? cnt_q[rcm_pkg::LimbW-1:0] : limb_q;

  always_ff @(posedge clk_i) begin
    if (mod_wr_i) begin
      mod_mem[mod_addr_i] <= mod_data_i;
    end
    if (ctrl_i.rd_q) begin
      q_q      <= mod_mem[addr];
      fac_rd_q <= fac_mem[addr];
    end
    if (ctrl_i.fac_wr && !mul_q) begin
      fac_mem[addr] <= rfin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fac_vld_q <= '0;
    end else if (ctrl_i.fac_wr && !mul_q) begin
      fac_vld_q[addr] <= 1'b1;
    end
  end

  always_comb begin
    unique case (ctrl_i.mul_step)
      2'd0: begin pa = ma_q[31:0];  pb = mb_q[31:0];  end
      2'd1: begin pa = ma_q[31:0];  pb = mb_q[63:32]; end
      2'd2: begin pa = ma_q[63:32]; pb = mb_q[31:0];  end
      default: begin pa = ma_q[63:32]; pb = mb_q[63:32]; end
    endcase
  end
  assign pp = 64'(pa) * 64'(pb);

  always_comb begin
    logic [rcm_pkg::ProdW-1:0] s;
    s   = neg_q ? (~acc_q + 1'b1) : acc_q;
    s   = s + rcm_pkg::ProdW'(32'h8000_0000);
    rnd = {{32{s[rcm_pkg::ProdW-1]}}, s[rcm_pkg::ProdW-1:32]};
  end

  logic [rcm_pkg::ValW-1:0] fac_eff;
  assign fac_eff = fac_vld_q[limb_q] ? fac_rd_q : '0;

  assign r2 = {r_q, val_q[rcm_pkg::ProdW-1]};
  logic [rcm_pkg::ValW:0] r2s;
  assign r2s = (r2 >= {1'b0, q_q}) ? r2 - {1'b0, q_q} : r2;
  assign rfin = (q_q == '0) ? '0 :
                ((lneg_q && !mul_q && r_q != '0) ? q_q - r_q : r_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      limb_q <= in_limb_i;
      ok_q   <= in_limb_ok_i;
      mul_q  <= is_mul_i;
      neg_q  <= const_i[63];
      ma_q   <= const_i[63] ? (~const_i + 1'b1) : const_i;
      mb_q   <= {2'b00, scale_i};
      a_q    <= coeff_i;
    end
    if (ctrl_i.mul_clear) begin
      acc_q <= '0;
    end else if (ctrl_i.mul_en) begin
      unique case (ctrl_i.mul_step)
        2'd0: acc_q <= acc_q + rcm_pkg::ProdW'(pp);
        2'd3: acc_q <= acc_q + {pp, 64'd0};
        default: acc_q <= acc_q + {32'd0, pp, 32'd0};
      endcase
    end
    if (ctrl_i.round) begin
      if (mul_q) begin
        val_q  <= acc_q;
      end else begin
        lneg_q <= rnd[rcm_pkg::ProdW-1];
        val_q  <= rnd[rcm_pkg::ProdW-1] ? (~rnd + 1'b1) : rnd;
      end
    end
    if (ctrl_i.mod_init) begin
      if (mul_q) begin
        ma_q  <= {2'b00, a_q};
        mb_q  <= {2'b00, fac_eff};
      end
      bit_q <= '0;
      r_q   <= '0;
    end else if (ctrl_i.mod_step) begin
      // rotate so the magnitude is back in place for the next limb
      r_q   <= r2s[rcm_pkg::ValW-1:0];
      val_q <= {val_q[rcm_pkg::ProdW-2:0], val_q[rcm_pkg::ProdW-1]};
      bit_q <= bit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (ctrl_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  logic [rcm_pkg::CountW-1:0] n_eff;
  assign n_eff = (count_i > rcm_pkg::CountW'(rcm_pkg::MaxLimbs)) ?
                 rcm_pkg::CountW'(rcm_pkg::MaxLimbs) : count_i;

  assign stat_o.mod_done = (bit_q == rcm_pkg::BitCntW'(rcm_pkg::ProdW - 1)) && ctrl_i.mod_step;
  assign stat_o.cnt_last = mul_q ? 1'b1 :
                           ((rcm_pkg::CountW'(cnt_q) + 1'b1) >= n_eff);
  assign stat_o.out_busy = ov_q && !out_ready_i;
  assign stat_o.is_mul   = mul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      ovl_q <= (mul_q && !ok_q) ? '0 : rfin;
      olm_q <= mul_q ? limb_q : cnt_q[rcm_pkg::LimbW-1:0];
      ol_q  <= stat_o.cnt_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_val_o   = ovl_q;
  assign out_limb_o  = olm_q;
  assign out_last_o  = ol_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> !stat_o.out_busy) else $error("emit into full output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q) else $error("output dropped");
  a_res_lt_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit && q_q != '0 |-> rfin < q_q) else $error("residue not reduced");
`endif

endmodule

>>> rtl/core/rcm_ctrl.sv
`timescale 1ns / 1ps
module rcm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic [1:0]      cmd_i,
  input  logic            count_zero_i,
  input  rcm_pkg::stat_t  stat_i,
  output rcm_pkg::ctrl_t  ctrl_o,
  output logic            idle_o
);

  rcm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    idle_o  = 1'b0;
    unique case (state_q)
      rcm_pkg::ST_IDLE: begin
        idle_o = 1'b1;
        ctrl_o.mul_clear = 1'b1;
        ctrl_o.cnt_clr   = 1'b1;
        if (in_fire_i) begin
          ctrl_o.latch_in = 1'b1;
          if (cmd_i == rcm_pkg::CMD_SETC && !count_zero_i) begin
            state_d = rcm_pkg::ST_MUL0;
          end else if (cmd_i == rcm_pkg::CMD_MUL) begin
            state_d = rcm_pkg::ST_RDQ;
          end
        end
      end
      rcm_pkg::ST_MUL0: begin
        ctrl_o.mul_en = 1'b1; ctrl_o.mul_step = 2'd0; state_d = rcm_pkg::ST_MUL1;
      end
      rcm_pkg::ST_MUL1: begin
        ctrl_o.mul_en = 1'b1; ctrl_o.mul_step = 2'd1; state_d = rcm_pkg::ST_MUL2;
      end
      rcm_pkg::ST_MUL2: begin
        ctrl_o.mul_en = 1'b1; ctrl_o.mul_step = 2'd2; state_d = rcm_pkg::ST_MUL3;
      end
      rcm_pkg::ST_MUL3: begin
        ctrl_o.mul_en = 1'b1; ctrl_o.mul_step = 2'd3; state_d = rcm_pkg::ST_ROUND;
      end
      rcm_pkg::ST_ROUND: begin
        ctrl_o.round = 1'b1;
        state_d = stat_i.is_mul ? rcm_pkg::ST_MODRUN : rcm_pkg::ST_RDQ;
      end
      rcm_pkg::ST_RDQ: begin
        ctrl_o.rd_q = 1'b1;
        ctrl_o.limb_sel_cnt = 1'b1;
        state_d = rcm_pkg::ST_MODINIT;
      end
      rcm_pkg::ST_MODINIT: begin
        ctrl_o.mod_init = 1'b1;
        state_d = stat_i.is_mul ? rcm_pkg::ST_MUL0 : rcm_pkg::ST_MODRUN;
      end
      rcm_pkg::ST_MODRUN: begin
        ctrl_o.mod_step = 1'b1;
        if (stat_i.mod_done) state_d = rcm_pkg::ST_EMIT;
      end
      rcm_pkg::ST_EMIT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.limb_sel_cnt = 1'b1;
          ctrl_o.fac_wr = 1'b1;
          if (stat_i.cnt_last) begin
            state_d = rcm_pkg::ST_IDLE;
          end else begin
            ctrl_o.cnt_inc = 1'b1;
            state_d = rcm_pkg::ST_RDQ;
          end
        end
      end
      default: state_d = rcm_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/rns_constant_multiply.sv
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata: cmd, limb_index, modulus_value,
//                                       constant_value, coeff_value
// m_axis    out  m_axis_tvalid/tready   tdata: result_value, result_limb; tlast: last
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
// One item at a time. Load modulus writes the table on acceptance. Multiply
// runs the 4-step 32x32 multiply and the bit-serial 128-step modular reduction.
// Set constant runs the 4-step 32x32 multiply and rounding once, then the
// 128-step reduction for each limb.
// Reset clears control and factor valid bits. A stalled output holds the
// sequencer before its next result.
module rns_constant_multiply (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [61:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // cmd[1:0], limb_index[6:2], modulus_value[68:7], constant_value[132:69],
  // coeff_value[194:133], zero pad to 200
  input  logic [199:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // result_value[61:0], result_limb[66:62], zero pad to 72
  output logic [71:0]   m_axis_tdata,
  output logic          m_axis_tlast
);

  logic [rcm_pkg::ValW-1:0]   scale_q;
  logic [rcm_pkg::CountW-1:0] count_q;
  rcm_pkg::ctrl_t ctrl;
  rcm_pkg::stat_t stat;
  logic idle, fire;
  logic [1:0] cmd;
  logic [rcm_pkg::ValW-1:0] val;
  logic [rcm_pkg::LimbW-1:0] olimb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= rcm_pkg::ValW'(1);
      count_q <= rcm_pkg::CountW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcm_pkg::CFG_SCALE: scale_q <= cfg_data_i;
        default:            count_q <= cfg_data_i[rcm_pkg::CountW-1:0];
      endcase
    end
  end

  assign s_axis_tready = idle;
  assign fire = s_axis_tvalid && s_axis_tready;
  assign cmd  = s_axis_tdata[1:0];

  rcm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i    (fire),
    .cmd_i        (cmd),
    .count_zero_i (count_q == '0),
    .stat_i       (stat),
    .ctrl_o       (ctrl),
    .idle_o       (idle)
  );

  rcm_datapath u_dp (
    .clk_i, .rst_ni,
    .scale_i      (scale_q),
    .count_i      (count_q),
    .mod_wr_i     (fire && cmd == rcm_pkg::CMD_LOAD),
    .mod_addr_i   (s_axis_tdata[6:2]),
    .mod_data_i   (s_axis_tdata[68:7]),
    .in_limb_i    (s_axis_tdata[6:2]),
    .in_limb_ok_i (1'b1),
    .const_i      (s_axis_tdata[132:69]),
    .coeff_i      (s_axis_tdata[194:133]),
    .is_mul_i     (cmd == rcm_pkg::CMD_MUL),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_val_o    (val),
    .out_limb_o   (olimb),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, olimb, val};

endmodule
